FILE: rtl/pss_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the paired sample statistics block
package pss_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_BITS     = 17;
   localparam logic [COUNT_BITS-1:0] MAX_SAMPLES = 17'h10000;

   // operand widths of the shared iterative arithmetic unit
   localparam int ARG_BITS       = 144;
   localparam int DIVISOR_BITS   = 128;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_x;
      logic signed [SAMPLE_BITS-1:0] sample_y;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]         sample_count;
      logic signed [SAMPLE_BITS-1:0] min_x;
      logic signed [SAMPLE_BITS-1:0] max_x;
      logic signed [SAMPLE_BITS-1:0] min_y;
      logic signed [SAMPLE_BITS-1:0] max_y;
      logic signed [23:0]            mean_x;
      logic [15:0]                   r_squared;
      logic                          corr_undefined;
      logic [38:0]                   variance_y;
      logic [24:0]                   std_dev_y;
      logic signed [31:0]            coef_variation;
      logic [54:0]                   total_sum_squares;
   } rsp_type;

   // accumulated sums and extremes of one data set
   typedef struct packed {
      logic [COUNT_BITS-1:0]         count;
      logic signed [32:0]            sum_x;
      logic signed [32:0]            sum_y;
      logic [46:0]                   sum_x_sq;
      logic [46:0]                   sum_y_sq;
      logic signed [47:0]            sum_xy;
      logic signed [SAMPLE_BITS-1:0] lowest_x;
      logic signed [SAMPLE_BITS-1:0] highest_x;
      logic signed [SAMPLE_BITS-1:0] lowest_y;
      logic signed [SAMPLE_BITS-1:0] highest_y;
   } snap_type;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

endpackage

FILE: rtl/pss_front.sv
`timescale 1ns / 1ps
// front end: accumulates sample pairs and hands finished sets to the queue
module pss_front import pss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output snap_type q_data
);

   snap_type acc_ff, acc_in;
   snap_type upd;
   logic signed [31:0] xx, yy, xy;
   logic take, room, first;

   always_comb begin
      req_ready = !q_full;
      take      = req_valid && req_ready;
      room      = acc_ff.count < MAX_SAMPLES;
      first     = acc_ff.count == '0;
      xx        = req_data.sample_x * req_data.sample_x;
      yy        = req_data.sample_y * req_data.sample_y;
      xy        = req_data.sample_x * req_data.sample_y;
      upd       = acc_ff;
      if (room) begin
         upd.count    = acc_ff.count + 17'd1;
         upd.sum_x    = acc_ff.sum_x + 33'(req_data.sample_x);
         upd.sum_y    = acc_ff.sum_y + 33'(req_data.sample_y);
         upd.sum_x_sq = acc_ff.sum_x_sq + 47'($unsigned(xx));
         upd.sum_y_sq = acc_ff.sum_y_sq + 47'($unsigned(yy));
         upd.sum_xy   = acc_ff.sum_xy + 48'(xy);
         if (first || req_data.sample_x < acc_ff.lowest_x) begin
            upd.lowest_x = req_data.sample_x;
         end
         if (first || req_data.sample_x > acc_ff.highest_x) begin
            upd.highest_x = req_data.sample_x;
         end
         if (first || req_data.sample_y < acc_ff.lowest_y) begin
            upd.lowest_y = req_data.sample_y;
         end
         if (first || req_data.sample_y > acc_ff.highest_y) begin
            upd.highest_y = req_data.sample_y;
         end
      end
      acc_in = acc_ff;
      if (take) begin
         acc_in = req_data.last_sample ? '0 : upd;
      end
      q_push = take && req_data.last_sample;
      q_data = upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: rtl/pss_queue.sv
`timescale 1ns / 1ps
// short queue of finished data sets between front and back
module pss_queue import pss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  snap_type push_data,
   input  logic     pop,
   output snap_type pop_data,
   output logic     full,
   output logic     empty
);

   snap_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   fill_ff, fill_in;

   always_comb begin
      full      = fill_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
      empty     = fill_ff == '0;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/pss_arith.sv
`timescale 1ns / 1ps
// shared iterative unit: shift-add multiply, restoring divide, integer square root
module pss_arith import pss_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  arith_ctl_type           ctl,
   input  logic [ARG_BITS-1:0]     opa,
   input  logic [DIVISOR_BITS-1:0] opb,
   output arith_sts_type           sts,
   output logic [ARG_BITS-1:0]     result
);

   localparam logic [7:0] MUL_STEPS  = 8'd64;
   localparam logic [7:0] DIV_STEPS  = 8'd144;
   localparam logic [7:0] SQRT_STEPS = 8'd24;

   logic busy_ff, busy_in, done_ff, done_in;
   arith_op_type op_ff, op_in;
   logic [7:0] iter_ff, iter_in;
   logic [127:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [63:0]  mplier_ff, mplier_in;
   logic [ARG_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [47:0] rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [DIVISOR_BITS:0] rem_sh;
   logic [47:0] cand;
   logic ge;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      iter_in   = iter_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      rem_sh    = {rem_ff, quo_ff[ARG_BITS-1]};
      ge        = rem_sh >= {1'b0, dvs_ff};
      cand      = root_ff + bit_ff;
      if (!busy_ff) begin
         if (ctl.start) begin
            busy_in   = 1'b1;
            op_in     = ctl.op;
            acc_in    = '0;
            mcand_in  = 128'(opa[63:0]);
            mplier_in = opb[63:0];
            quo_in    = opa;
            rem_in    = '0;
            dvs_in    = opb;
            rad_in    = opa[47:0];
            root_in   = '0;
            bit_in    = 48'h4000_0000_0000;
            case (ctl.op)
               OP_MUL:  iter_in = MUL_STEPS;
               OP_DIV:  iter_in = DIV_STEPS;
               OP_SQRT: iter_in = SQRT_STEPS;
               default: iter_in = MUL_STEPS;
            endcase
         end
      end else begin
         case (op_ff)
            OP_MUL: begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[126:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[63:1]};
            end
            OP_DIV: begin
               rem_in = ge ? rem_sh[DIVISOR_BITS-1:0] - dvs_ff : rem_sh[DIVISOR_BITS-1:0];
               quo_in = {quo_ff[ARG_BITS-2:0], ge};
            end
            OP_SQRT: begin
               if (rad_ff >= cand) begin
                  rad_in  = rad_ff - cand;
                  root_in = {1'b0, root_ff[47:1]} + bit_ff;
               end else begin
                  root_in = {1'b0, root_ff[47:1]};
               end
               bit_in = {2'b00, bit_ff[47:2]};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         iter_in = iter_ff - 8'd1;
         if (iter_ff == 8'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      sts.busy = busy_ff;
      sts.done = done_ff;
      case (op_ff)
         OP_MUL:  result = ARG_BITS'(acc_ff);
         OP_DIV:  result = quo_ff;
         OP_SQRT: result = ARG_BITS'(root_ff);
         default: result = quo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      iter_ff   <= iter_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: rtl/pss_back.sv
`timescale 1ns / 1ps
// back end: sequences the final statistics of one set through the shared unit
module pss_back import pss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  snap_type                 q_data,
   output logic                     q_pop,
   output arith_ctl_type            ctl,
   output logic [ARG_BITS-1:0]      opa,
   output logic [DIVISOR_BITS-1:0]  opb,
   input  arith_sts_type            sts,
   input  logic [ARG_BITS-1:0]      result,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data
);

   localparam logic [31:0] CV_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CV_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      MUL_N_SXY  = 4'd0,
      MUL_SX_SY  = 4'd1,
      MUL_N_SXX  = 4'd2,
      MUL_SX_SX  = 4'd3,
      MUL_N_SYY  = 4'd4,
      MUL_SY_SY  = 4'd5,
      MUL_NUM_SQ = 4'd6,
      MUL_DX_DY  = 4'd7,
      DIV_R2     = 4'd8,
      MUL_N_N    = 4'd9,
      DIV_VAR    = 4'd10,
      SQRT_SD    = 4'd11,
      MUL_SD_N   = 4'd12,
      DIV_CV     = 4'd13,
      DIV_MX     = 4'd14,
      MUL_N_VAR  = 4'd15
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   snap_type  snap_ff, snap_in;
   logic signed [63:0] p1_ff, p1_in;
   logic [62:0]  num_ff, num_in, da_ff, da_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [125:0] nn_ff, nn_in, dd_ff, dd_in;
   logic [15:0]  r2_ff, r2_in;
   logic [32:0]  n2_ff, n2_in;
   logic [38:0]  var_ff, var_in;
   logic [24:0]  sd_ff, sd_in;
   logic [40:0]  t_ff, t_in;
   logic [31:0]  cv_ff, cv_in;
   logic [23:0]  mx_ff, mx_in;
   logic [54:0]  tss_ff, tss_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic sx_neg, sy_neg, sxy_neg, bad, out_free;
   logic [31:0] sxm, sym;
   logic [46:0] sxym;
   logic [63:0] prod, quot;
   logic signed [63:0] prod_s;
   logic signed [64:0] diff;
   logic [64:0] diff_mag;
   logic [62:0] res_lo;

   always_comb begin
      sx_neg  = snap_ff.sum_x[32];
      sy_neg  = snap_ff.sum_y[32];
      sxy_neg = snap_ff.sum_xy[47];
      sxm     = sx_neg ? 32'(33'd0 - snap_ff.sum_x) : snap_ff.sum_x[31:0];
      sym     = sy_neg ? 32'(33'd0 - snap_ff.sum_y) : snap_ff.sum_y[31:0];
      sxym    = sxy_neg ? 47'(48'd0 - snap_ff.sum_xy) : snap_ff.sum_xy[46:0];
      bad     = dx_ff == '0 || dy_ff == '0;
      res_lo  = result[62:0];
      prod    = {1'b0, res_lo};
      prod_s  = (sx_neg ^ sy_neg) ? $signed(64'd0 - prod) : $signed(prod);
      diff    = 65'(p1_ff) - 65'(prod_s);
      diff_mag = diff[64] ? 65'd0 - diff : diff;
      quot    = result[63:0];
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // operand routing for the current step
   always_comb begin
      ctl.start = state_ff == ST_ISSUE;
      ctl.op    = OP_MUL;
      opa       = '0;
      opb       = '0;
      case (step_ff)
         MUL_N_SXY: begin
            opa = ARG_BITS'(snap_ff.count);
            opb = DIVISOR_BITS'(sxym);
         end
         MUL_SX_SY: begin
            opa = ARG_BITS'(sxm);
            opb = DIVISOR_BITS'(sym);
         end
         MUL_N_SXX: begin
            opa = ARG_BITS'(snap_ff.count);
            opb = DIVISOR_BITS'(snap_ff.sum_x_sq);
         end
         MUL_SX_SX: begin
            opa = ARG_BITS'(sxm);
            opb = DIVISOR_BITS'(sxm);
         end
         MUL_N_SYY: begin
            opa = ARG_BITS'(snap_ff.count);
            opb = DIVISOR_BITS'(snap_ff.sum_y_sq);
         end
         MUL_SY_SY: begin
            opa = ARG_BITS'(sym);
            opb = DIVISOR_BITS'(sym);
         end
         MUL_NUM_SQ: begin
            opa = ARG_BITS'(num_ff);
            opb = DIVISOR_BITS'(num_ff);
         end
         MUL_DX_DY: begin
            opa = ARG_BITS'(dx_ff);
            opb = DIVISOR_BITS'(dy_ff);
         end
         DIV_R2: begin
            ctl.op = OP_DIV;
            opa    = ARG_BITS'(nn_ff) << 15;
            opb    = DIVISOR_BITS'(dd_ff);
         end
         MUL_N_N: begin
            opa = ARG_BITS'(snap_ff.count);
            opb = DIVISOR_BITS'(snap_ff.count);
         end
         DIV_VAR: begin
            ctl.op = OP_DIV;
            opa    = ARG_BITS'(dy_ff) << 8;
            opb    = DIVISOR_BITS'(n2_ff);
         end
         SQRT_SD: begin
            ctl.op = OP_SQRT;
            opa    = ARG_BITS'(var_ff) << 8;
         end
         MUL_SD_N: begin
            opa = ARG_BITS'(sd_ff);
            opb = DIVISOR_BITS'(snap_ff.count);
         end
         DIV_CV: begin
            ctl.op = OP_DIV;
            opa    = ARG_BITS'(t_ff) << 8;
            opb    = DIVISOR_BITS'(sym);
         end
         DIV_MX: begin
            ctl.op = OP_DIV;
            opa    = ARG_BITS'(sxm) << 8;
            opb    = DIVISOR_BITS'(snap_ff.count);
         end
         MUL_N_VAR: begin
            opa = ARG_BITS'(snap_ff.count);
            opb = DIVISOR_BITS'(var_ff);
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      snap_in      = snap_ff;
      p1_in        = p1_ff;
      num_in       = num_ff;
      da_in        = da_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      nn_in        = nn_ff;
      dd_in        = dd_ff;
      r2_in        = r2_ff;
      n2_in        = n2_ff;
      var_in       = var_ff;
      sd_in        = sd_ff;
      t_in         = t_ff;
      cv_in        = cv_ff;
      mx_in        = mx_ff;
      tss_in       = tss_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               snap_in  = q_data;
               step_in  = MUL_N_SXY;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.done) begin
               case (step_ff)
                  MUL_N_SXY:  p1_in = sxy_neg ? $signed(64'd0 - prod) : $signed(prod);
                  MUL_SX_SY:  num_in = diff_mag[62:0];
                  MUL_N_SXX:  da_in = res_lo;
                  MUL_SX_SX:  dx_in = res_lo > da_ff ? '0 : da_ff - res_lo;
                  MUL_N_SYY:  da_in = res_lo;
                  MUL_SY_SY:  dy_in = res_lo > da_ff ? '0 : da_ff - res_lo;
                  MUL_NUM_SQ: nn_in = result[125:0];
                  MUL_DX_DY:  dd_in = result[125:0];
                  DIV_R2:     r2_in = bad ? '0 : result[15:0];
                  MUL_N_N:    n2_in = result[32:0];
                  DIV_VAR:    var_in = result[38:0];
                  SQRT_SD:    sd_in = result[24:0];
                  MUL_SD_N:   t_in = result[40:0];
                  DIV_CV: begin
                     if (snap_ff.sum_y == '0) begin
                        cv_in = CV_MAX;
                     end else if (sy_neg) begin
                        cv_in = quot > 64'(CV_MIN) ? CV_MIN : 32'(64'd0 - quot);
                     end else begin
                        cv_in = quot > 64'(CV_MAX) ? CV_MAX : quot[31:0];
                     end
                  end
                  DIV_MX:     mx_in = sx_neg ? 24'd0 - result[23:0] : result[23:0];
                  MUL_N_VAR:  tss_in = result[54:0];
                  default:    tss_in = tss_ff;
               endcase
               if (step_ff == MUL_N_VAR) begin
                  state_in = ST_EMIT;
               end else begin
                  step_in  = step_type'(step_ff + 4'd1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.sample_count      = snap_ff.count;
               rsp_data_in.min_x             = snap_ff.lowest_x;
               rsp_data_in.max_x             = snap_ff.highest_x;
               rsp_data_in.min_y             = snap_ff.lowest_y;
               rsp_data_in.max_y             = snap_ff.highest_y;
               rsp_data_in.mean_x            = mx_ff;
               rsp_data_in.r_squared         = r2_ff;
               rsp_data_in.corr_undefined    = bad;
               rsp_data_in.variance_y        = var_ff;
               rsp_data_in.std_dev_y         = sd_ff;
               rsp_data_in.coef_variation    = cv_ff;
               rsp_data_in.total_sum_squares = tss_ff;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      snap_ff     <= snap_in;
      p1_ff       <= p1_in;
      num_ff      <= num_in;
      da_ff       <= da_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      nn_ff       <= nn_in;
      dd_ff       <= dd_in;
      r2_ff       <= r2_in;
      n2_ff       <= n2_in;
      var_ff      <= var_in;
      sd_ff       <= sd_in;
      t_ff        <= t_in;
      cv_ff       <= cv_in;
      mx_ff       <= mx_in;
      tss_ff      <= tss_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !sts.busy) else $error("unit started while busy");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty queue");
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> state_ff == ST_WAIT) else $error("result outside wait state");
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("emit did not load result");
`endif

endmodule

FILE: rtl/paired_sample_statistics.sv
`timescale 1ns / 1ps
// top level of the paired sample statistics block
// Accepts one signed (x, y) pair per cycle and accumulates count, sums, sums of
// squares, the cross sum and the extremes of x and y. The pair marked last_sample
// closes a set: its sums go to a two-entry queue and the accumulator starts over
// with the next pair. A sequencer then works the final statistics out on
// one shared iterative unit (shift-add multiply, restoring divide, 24-step
// square root) and places the item in an output register. Pairs keep flowing at
// one per cycle while that runs; input stalls only when two finished sets wait in
// the queue. Pairs beyond 65536 in a set are dropped, though their last mark still
// closes the set.
module paired_sample_statistics import pss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // front to queue
   logic          push, q_full, q_empty, q_pop;
   snap_type      push_data, pop_data;
   // back to shared unit
   arith_ctl_type ctl;
   arith_sts_type sts;
   logic [ARG_BITS-1:0]     opa, result;
   logic [DIVISOR_BITS-1:0] opb;

   pss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (push),
      .q_data    (push_data)
   );

   pss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   pss_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opa    (opa),
      .opb    (opb),
      .sts    (sts),
      .result (result)
   );

   pss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .ctl       (ctl),
      .opa       (opa),
      .opb       (opb),
      .sts       (sts),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for the paired sample statistics block
module testbench;
   import pss_pkg::*;

   // idle cycles with no accepted item before the run is declared hung
   localparam int STALL_LIMIT = 20000;
   // wait after the last expected result before the final verdict
   localparam int SET_LATENCY = 2000;
   localparam int HOLD_CYCLES = 3000;

   // ------------------------------------------------------------------
   // scoreboard: mirrors the accumulator and keeps the expected results
   // ------------------------------------------------------------------
   class stats_scoreboard;
      bit [63:0] cnt, sx, sy, sxx, syy, sxy;
      logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
      rsp_type expected_stats[$];
      int mismatches;

      function void clear_set();
         cnt = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
         lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
      endfunction

      function new();
         clear_set();
         mismatches = 0;
      endfunction

      function bit [63:0] magnitude(bit [63:0] v);
         return v[63] ? -v : v;
      endfunction

      function bit [63:0] int_sqrt(bit [63:0] v);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      // accumulate one accepted pair; a last mark closes the set
      function void note_pair(req_type p);
         bit [63:0] ux, uy, n, num, dx, dy, n2, vy, sd, r2, mx, cvm, cv;
         bit [127:0] rem, den;
         bit undef;
         rsp_type r;
         ux = 64'(p.sample_x);
         uy = 64'(p.sample_y);
         if (cnt < 64'(MAX_SAMPLES)) begin
            if (cnt == 0) begin
               lo_x = p.sample_x; hi_x = p.sample_x;
               lo_y = p.sample_y; hi_y = p.sample_y;
            end else begin
               if (p.sample_x < lo_x) lo_x = p.sample_x;
               if (p.sample_x > hi_x) hi_x = p.sample_x;
               if (p.sample_y < lo_y) lo_y = p.sample_y;
               if (p.sample_y > hi_y) hi_y = p.sample_y;
            end
            sx += ux; sy += uy;
            sxx += ux * ux; syy += uy * uy; sxy += ux * uy;
            cnt++;
         end
         if (!p.last_sample) return;

         n = (cnt != 0) ? cnt : 64'd1;
         mx = (magnitude(sx) << 8) / n;
         if (sx[63]) mx = -mx;

         // squared correlation by restoring division, 15 fraction bits
         num = magnitude(n * sxy - sx * sy);
         dx = n * sxx - sx * sx;
         dy = n * syy - sy * sy;
         if (dx[63]) dx = 0;
         if (dy[63]) dy = 0;
         r2 = 0;
         undef = (dx == 0 || dy == 0);
         if (!undef) begin
            rem = {64'd0, num} * {64'd0, num};
            den = {64'd0, dx} * {64'd0, dy};
            for (int i = 0; i < 16; i++) begin
               if (i != 0) rem = rem << 1;
               r2 = r2 << 1;
               if (rem >= den) begin
                  rem = rem - den;
                  r2[0] = 1'b1;
               end
            end
         end

         n2 = n * n;
         vy = (dy / n2) * 256 + ((dy % n2) * 256) / n2;
         sd = int_sqrt(vy * 256);

         // zero y sum gives the positive limit, otherwise saturate
         if (sy == 0) begin
            cv = 64'h7FFF_FFFF;
         end else begin
            cvm = (sd * n * 256) / magnitude(sy);
            if (sy[63]) cv = (cvm > 64'h8000_0000) ? 64'h8000_0000 : -cvm;
            else cv = (cvm > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : cvm;
         end

         r.sample_count      = cnt[16:0];
         r.min_x             = lo_x;
         r.max_x             = hi_x;
         r.min_y             = lo_y;
         r.max_y             = hi_y;
         r.mean_x            = mx[23:0];
         r.r_squared         = r2[15:0];
         r.corr_undefined    = undef;
         r.variance_y        = vy[38:0];
         r.std_dev_y         = sd[24:0];
         r.coef_variation    = cv[31:0];
         r.total_sum_squares = 55'(cnt * vy);
         expected_stats.push_back(r);
         clear_set();
      endfunction

      function bit field_ok(string name, bit [63:0] e, bit [63:0] a);
         if (e == a) return 1;
         if (mismatches < 10)
            $display("mismatch %s: expected %h actual %h", name, e, a);
         return 0;
      endfunction

      function void check_stats(rsp_type a);
         rsp_type e;
         bit ok;
         if (expected_stats.size() == 0) begin
            if (mismatches < 10) $display("mismatch: result with nothing expected");
            mismatches++;
            return;
         end
         e = expected_stats.pop_front();
         ok = 1;
         ok &= field_ok("sample_count", e.sample_count, a.sample_count);
         ok &= field_ok("min_x", e.min_x, a.min_x);
         ok &= field_ok("max_x", e.max_x, a.max_x);
         ok &= field_ok("min_y", e.min_y, a.min_y);
         ok &= field_ok("max_y", e.max_y, a.max_y);
         ok &= field_ok("mean_x", e.mean_x, a.mean_x);
         ok &= field_ok("r_squared", e.r_squared, a.r_squared);
         ok &= field_ok("corr_undefined", e.corr_undefined, a.corr_undefined);
         ok &= field_ok("variance_y", e.variance_y, a.variance_y);
         ok &= field_ok("std_dev_y", e.std_dev_y, a.std_dev_y);
         ok &= field_ok("coef_variation", e.coef_variation, a.coef_variation);
         ok &= field_ok("total_sum_squares", e.total_sum_squares, a.total_sum_squares);
         if (!ok) mismatches++;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   stats_scoreboard sb;
   bit quiet;        // no idling on either side while set
   bit hold_rsp;     // receiver takes one long break when set
   int idle_cycles;
   int pair_total;

   paired_sample_statistics i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   // accepted items on both channels go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_pair(req_data);
         if (rsp_valid && rsp_ready) sb.check_stats(rsp_data);
      end
   end

   // watchdog over cycles with no item accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // offer one pair; valid stays up across back-to-back items
   task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample_x: x, sample_y: y, last_sample: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pair_total++;
   endtask

   function automatic logic signed [15:0] draw_value();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(signed'($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // a set of random pairs, last one marked
   task automatic send_set(int size);
      for (int i = 0; i < size; i++)
         send_pair(draw_value(), draw_value(), i == size - 1);
   endtask

   // receiver: random stalls per item, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         int w;
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            w = quiet ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
               rsp_ready <= 1'b0;
               repeat (w) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet = 0;
      hold_rsp = 0;
      pair_total = 0;
      idle_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pair at the negative extreme: variance zero, correlation undefined
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      // single pair at the positive extreme
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      // all y zero: zero y sum
      send_pair(16'sd3, 16'sd0, 1'b0);
      send_pair(-16'sd9, 16'sd0, 1'b1);
      // y sums to zero with spread: coefficient at its maximum
      send_pair(16'sh7FFF, 16'sd5, 1'b0);
      send_pair(16'sh8000, -16'sd5, 1'b1);
      // tiny negative y mean, wide spread: negative saturation
      send_pair(16'sd1, 16'sh7FFF, 1'b0);
      send_pair(16'sd2, 16'sh8000, 1'b1);
      // tiny positive y mean, wide spread: positive saturation
      send_pair(16'sd1, -16'sd32767, 1'b0);
      send_pair(-16'sd4, 16'sd32767, 1'b0);
      send_pair(16'sd0, 16'sd1, 1'b1);
      // perfect correlation of extremes
      send_pair(16'sh8000, 16'sh8000, 1'b0);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b1);
      // anticorrelated, constant x gives undefined correlation
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(-16'sd7, 16'sd100, 1'b0);
      send_pair(-16'sd7, -16'sd3, 1'b1);

      // receiver stops while pairs keep coming, so the queue backs up
      hold_rsp = 1;
      repeat (6) send_set($urandom_range(1, 4));

      while (pair_total < 850) begin
         // some stretches with no idling at all
         quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) send_set($urandom_range(9, 60));
         else send_set($urandom_range(1, 8));
      end
      quiet = 0;
      req_valid <= 1'b0;

      while (sb.expected_stats.size() != 0) @(posedge clock);
      repeat (SET_LATENCY) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_stats.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/pss_pkg.sv
rtl/pss_front.sv
rtl/pss_queue.sv
rtl/pss_arith.sv
rtl/pss_back.sv
rtl/paired_sample_statistics.sv
tb/sv/testbench.sv
